// File: hw/rtl/eapg_pkg.sv
// Shared types, constants and the sine table builder for the arc point generator.
package eapg_pkg;

  localparam int unsigned StepsPerTurnDefault = 40;
  localparam int unsigned SineTableDepthDefault = 1024;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 6;
  localparam int unsigned AccW = 24;
  localparam int unsigned MagW = 17;
  localparam int unsigned TrigW = 15;
  localparam int unsigned DivSteps = 24;
  localparam int unsigned DivCntW = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_RD_COS,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SUM_Y,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic mul_x;
    logic mul_y;
    logic sum_y;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic last_point;
  } status_t;

  // One quarter-wave entry in Q14 from a Q30 angle, Taylor series to x^15.
  function automatic logic [TrigW-1:0] sine_entry(input logic [63:0] x);
    logic [63:0] t;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    t = x;
    sum = $signed(x);
    for (int i = 1; i <= 7; i++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      case (i)
        1: t = t / 64'd6;
        2: t = t / 64'd20;
        3: t = t / 64'd42;
        4: t = t / 64'd72;
        5: t = t / 64'd110;
        6: t = t / 64'd156;
        default: t = t / 64'd210;
      endcase
      if (i % 2 == 1) sum = sum - $signed(t);
      else sum = sum + $signed(t);
    end
    if (sum < 0) sum = 0;
    q = $signed((64'(sum) + 64'd32768) >> 16);
    if (q > 16384) q = 16384;
    return TrigW'(q);
  endfunction

endpackage

// File: hw/rtl/eapg_sine_rom.sv
// Quarter-wave sine table with a registered read port.
module eapg_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = eapg_pkg::SineTableDepthDefault,
  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic [IdxW-1:0]            addr_i,
  output logic [eapg_pkg::TrigW-1:0] data_o
);

  logic [eapg_pkg::TrigW-1:0] rom_tbl [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tbl
    assign rom_tbl[k] = eapg_pkg::sine_entry(
      64'(k) * eapg_pkg::HalfPiQ30 / 64'(SINE_TABLE_DEPTH));
  end

  always_ff @(posedge clk_i) begin
    data_o <= rom_tbl[addr_i];
  end

endmodule

// File: hw/rtl/eapg_datapath.sv
// Arc datapath: latched request, step divider, angle accumulator, trig and coordinate math.
module eapg_datapath #(
  parameter int unsigned STEPS_PER_TURN   = eapg_pkg::StepsPerTurnDefault,
  parameter int unsigned SINE_TABLE_DEPTH = eapg_pkg::SineTableDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eapg_pkg::cmd_t       cmd_i,
  output eapg_pkg::status_t    status_o,
  input  logic signed [15:0]   center_x_i,
  input  logic signed [15:0]   center_y_i,
  input  logic signed [15:0]   radius_x_i,
  input  logic signed [15:0]   radius_y_i,
  input  logic signed [15:0]   begin_angle_i,
  input  logic signed [15:0]   end_angle_i,
  input  logic                 sweep_increasing_i,
  output logic signed [15:0]   point_x_o,
  output logic signed [15:0]   point_y_o,
  output logic [5:0]           point_number_o
);

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned AccW = eapg_pkg::AccW;
  localparam int unsigned MagW = eapg_pkg::MagW;
  localparam int unsigned TrigW = eapg_pkg::TrigW;
  localparam int unsigned CntW = eapg_pkg::CountW;

  logic signed [15:0] cx_q, cy_q;
  logic [MagW-1:0]    magx_q, magy_q;
  logic               sweep_q;
  logic [15:0]        span_q;
  logic [CntW-1:0]    n_q;
  logic [AccW-1:0]    acc_q;
  logic [AccW-1:0]    quo_q;
  logic [CntW-1:0]    rem_q;
  logic [eapg_pkg::DivCntW-1:0] div_cnt_q;
  logic [CntW-1:0]    idx_q;
  logic               neg_q, prod_neg_q;
  logic [MagW+TrigW-1:0] prod_q;
  logic signed [15:0] x_q, y_q;

  logic [TrigW-1:0]   rom_data;
  logic [IdxW-1:0]    rom_addr;

  // Count of steps from the span.
  logic [22:0]     steps_wide;
  logic [CntW-1:0] n_c;
  assign steps_wide = 23'(span_q) * 23'(STEPS_PER_TURN) + 23'd65535;
  assign n_c = CntW'(steps_wide >> 16);

  // One restoring divide step.
  logic [CntW:0]   rem_sh;
  logic [CntW+1:0] diff;
  assign rem_sh = {rem_q, quo_q[AccW-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, n_q};

  // Angle of the current point, and its table lookups.
  logic [15:0] ang_sin, ang_cos;
  assign ang_sin = 16'((acc_q + 24'd128) >> 8);
  assign ang_cos = ang_sin + 16'd16384;

  function automatic logic [IdxW:0] trig_index(input logic [15:0] a);
    logic [14:0] o;
    logic [29:0] p;
    o = {1'b0, a[13:0]};
    if (a[14]) o = 15'd16384 - o;
    p = 30'(o) * 30'(SINE_TABLE_DEPTH);
    return {a[15], IdxW'(p >> 14)};
  endfunction

  logic [IdxW:0] sin_ix, cos_ix;
  assign sin_ix = trig_index(ang_sin);
  assign cos_ix = trig_index(ang_cos);
  assign rom_addr = cmd_i.mul_x ? sin_ix[IdxW-1:0] : cos_ix[IdxW-1:0];

  eapg_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // Round the held Q14 product to an integer and add the center, saturating.
  function automatic logic signed [15:0] coord(input logic signed [15:0] c,
                                               input logic [MagW+TrigW-1:0] p,
                                               input logic neg);
    logic signed [MagW+TrigW:0] v;
    logic signed [MagW+TrigW:0] r;
    logic signed [19:0] s;
    v = $signed({1'b0, p});
    if (neg) v = -v;
    r = (v + 33'sd8192) >>> 14;
    s = 20'(c) + 20'(r);
    if (s > 20'sd32767) s = 20'sd32767;
    else if (s < -20'sd32768) s = -20'sd32768;
    return 16'(s);
  endfunction

  logic [AccW-1:0] inc;
  assign inc = sweep_q ? quo_q : AccW'(0) - quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.setup) div_cnt_q <= '0;
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q + 1'b1;
      if (cmd_i.load) idx_q <= '0;
      else if (cmd_i.advance) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= cmd_i.mul_x ? sin_ix[IdxW] : cos_ix[IdxW];
    if (cmd_i.load) begin
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      magx_q  <= radius_x_i[15] ? MagW'(0) - MagW'(radius_x_i) : MagW'(radius_x_i);
      magy_q  <= radius_y_i[15] ? MagW'(0) - MagW'(radius_y_i) : MagW'(radius_y_i);
      sweep_q <= sweep_increasing_i;
      span_q  <= sweep_increasing_i ? end_angle_i - begin_angle_i
                                    : begin_angle_i - end_angle_i;
      acc_q   <= {begin_angle_i, 8'h00};
    end
    if (cmd_i.setup) begin
      n_q   <= n_c;
      quo_q <= {span_q, 8'h00} + AccW'(n_c >> 1);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= diff[CntW+1] ? rem_sh[CntW-1:0] : diff[CntW-1:0];
      quo_q <= {quo_q[AccW-2:0], ~diff[CntW+1]};
    end
    if (cmd_i.mul_x) begin
      prod_q     <= magx_q * rom_data;
      prod_neg_q <= neg_q;
    end
    if (cmd_i.mul_y) begin
      x_q        <= coord(cx_q, prod_q, prod_neg_q);
      prod_q     <= magy_q * rom_data;
      prod_neg_q <= neg_q;
    end
    if (cmd_i.sum_y) y_q <= coord(cy_q, prod_q, prod_neg_q);
    if (cmd_i.advance) acc_q <= acc_q + inc;
  end

  assign status_o.div_last   = div_cnt_q == eapg_pkg::DivCntW'(eapg_pkg::DivSteps - 1);
  assign status_o.last_point = idx_q == n_q;
  assign point_x_o      = x_q;
  assign point_y_o      = y_q;
  assign point_number_o = idx_q;

endmodule

// File: hw/rtl/eapg_ctrl.sv
// Sequencer for the arc point generator.
module eapg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  eapg_pkg::status_t status_i,
  output eapg_pkg::cmd_t    cmd_o
);

  eapg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= eapg_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      eapg_pkg::ST_IDLE:   if (in_valid_i) state_d = eapg_pkg::ST_SETUP;
      eapg_pkg::ST_SETUP:  state_d = eapg_pkg::ST_DIVIDE;
      eapg_pkg::ST_DIVIDE: if (status_i.div_last) state_d = eapg_pkg::ST_RD_COS;
      eapg_pkg::ST_RD_COS: state_d = eapg_pkg::ST_MUL_X;
      eapg_pkg::ST_MUL_X:  state_d = eapg_pkg::ST_MUL_Y;
      eapg_pkg::ST_MUL_Y:  state_d = eapg_pkg::ST_SUM_Y;
      eapg_pkg::ST_SUM_Y:  state_d = eapg_pkg::ST_EMIT;
      eapg_pkg::ST_EMIT: begin
        if (!out_stall_i) begin
          state_d = status_i.last_point ? eapg_pkg::ST_IDLE : eapg_pkg::ST_RD_COS;
        end
      end
      default: state_d = eapg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      eapg_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      eapg_pkg::ST_SETUP:  cmd_o.setup = 1'b1;
      eapg_pkg::ST_DIVIDE: cmd_o.div_step = 1'b1;
      eapg_pkg::ST_RD_COS: ;
      eapg_pkg::ST_MUL_X:  cmd_o.mul_x = 1'b1;
      eapg_pkg::ST_MUL_Y:  cmd_o.mul_y = 1'b1;
      eapg_pkg::ST_SUM_Y:  cmd_o.sum_y = 1'b1;
      eapg_pkg::ST_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = !out_stall_i;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ellipse_arc_point_generator.sv
// Top level of the elliptical arc point generator.
// Takes one arc word (center, radii used by magnitude, begin and end binary
// angles, sweep direction) and emits n+1 point words, n being the span cut
// into STEPS_PER_TURN steps per full turn. After an arc is accepted, a setup
// state and a bit-serial divider produce the angle step; each point then
// passes through the cosine read, x multiply, y multiply and y sum states on
// the single sine table port and the shared product register, and waits in
// the emit state until it is taken. The next arc is accepted once the last
// point has been taken. The table is built at elaboration; there is no
// clearing pass after reset.
module ellipse_arc_point_generator #(
  parameter int unsigned STEPS_PER_TURN   = eapg_pkg::StepsPerTurnDefault,
  parameter int unsigned SINE_TABLE_DEPTH = eapg_pkg::SineTableDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] radius_x_i,
  input  logic signed [15:0] radius_y_i,
  input  logic signed [15:0] begin_angle_i,
  input  logic signed [15:0] end_angle_i,
  input  logic               sweep_increasing_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [5:0]         point_number_o,
  output logic               last_point_o
);

  eapg_pkg::cmd_t    cmd;
  eapg_pkg::status_t status;

  // Sequence the arc: load, divide, then compute and emit each point.
  eapg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eapg_datapath #(
    .STEPS_PER_TURN   (STEPS_PER_TURN),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .center_x_i         (center_x_i),
    .center_y_i         (center_y_i),
    .radius_x_i         (radius_x_i),
    .radius_y_i         (radius_y_i),
    .begin_angle_i      (begin_angle_i),
    .end_angle_i        (end_angle_i),
    .sweep_increasing_i (sweep_increasing_i),
    .point_x_o          (point_x_o),
    .point_y_o          (point_y_o),
    .point_number_o     (point_number_o)
  );

  assign last_point_o = status.last_point;

  // Hold off new arcs while points are being emitted.
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("arc accepted while emitting");

  // Drop valid after the last point of an arc is taken.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_point_o |=> !out_valid_o)
    else $error("output after last point");

  // First point of an arc is numbered zero.
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) && $past(in_stall_o) && !$past(in_valid_i && !in_stall_o)
      && $past(point_number_o) == 6'd0 |-> point_number_o == 6'd0)
    else $error("point number moved before emit");

  // An accepted arc makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("not busy after accept");

endmodule

// File: test/arc_point_checker.sv
// Checker for the arc point generator: predicts arc points and compares output words.
module arc_point_checker #(
  parameter int unsigned STEPS_PER_TURN   = eapg_pkg::StepsPerTurnDefault,
  parameter int unsigned SINE_TABLE_DEPTH = eapg_pkg::SineTableDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] radius_x_i,
  input  logic signed [15:0] radius_y_i,
  input  logic signed [15:0] begin_angle_i,
  input  logic signed [15:0] end_angle_i,
  input  logic               sweep_increasing_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [5:0]         point_number_i,
  input  logic               last_point_i,
  output int                 fail_count_o,
  output int                 pending_points_o
);

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [5:0]         num;
    logic               last;
  } arc_point_t;

  arc_point_t expected_points[$];
  int unsigned sine_lut[SINE_TABLE_DEPTH+1];

  initial begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      longint unsigned x, t;
      longint sum, q;
      x = (longint'(k) * 64'd1686629713) / SINE_TABLE_DEPTH;
      t = x;
      sum = x;
      for (int i = 1; i <= 7; i++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / ((2 * i) * (2 * i + 1));
        if (i % 2 == 1) sum = sum - longint'(t);
        else sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      q = (longint'(sum) + 32768) >>> 16;
      if (q > 16384) q = 16384;
      sine_lut[k] = 32'(q);
    end
  end

  function automatic int sine_q14(input logic [15:0] a);
    logic [1:0] quad;
    int unsigned off, idx;
    quad = a[15:14];
    off = 32'(a[13:0]);
    if (quad[0]) off = 16384 - off;
    idx = 32'((longint'(off) * SINE_TABLE_DEPTH) / 16384);
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    return quad[1] ? -int'(sine_lut[idx]) : int'(sine_lut[idx]);
  endfunction

  function automatic logic [15:0] place_coord(input int center, input int mag, input int trig);
    longint p, r, s;
    p = longint'(mag) * trig + 8192;
    if (p >= 0) r = p / 16384;
    else r = -((-p + 16383) / 16384);
    s = center + r;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  // Expand one arc word into its points.
  task automatic predict_arc_points();
    int cx, cy, rx, ry;
    logic [15:0] b, e, span, a;
    int unsigned n, mag;
    logic [23:0] acc;
    logic [24:0] inc;
    arc_point_t pt;
    cx = center_x_i;
    cy = center_y_i;
    rx = radius_x_i;
    ry = radius_y_i;
    if (rx < 0) rx = -rx;
    if (ry < 0) ry = -ry;
    b = begin_angle_i;
    e = end_angle_i;
    span = sweep_increasing_i ? e - b : b - e;
    n = 32'((longint'(span) * STEPS_PER_TURN + 65535) >> 16);
    acc = {b, 8'd0};
    inc = '0;
    if (n != 0) begin
      mag = ((int'(span) << 8) + n / 2) / n;
      inc = sweep_increasing_i ? 25'(mag) : 25'(-mag);
    end
    for (int i = 0; i <= n; i++) begin
      a = 16'((acc + 24'd128) >> 8);
      pt.px = place_coord(cx, rx, sine_q14(a + 16'd16384));
      pt.py = place_coord(cy, ry, sine_q14(a));
      pt.num = 6'(i);
      pt.last = (i == n);
      expected_points.push_back(pt);
      acc = acc + inc[23:0];
    end
  endtask

  assign pending_points_o = expected_points.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_arc_points();
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $error("point word with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          arc_point_t x;
          x = expected_points.pop_front();
          if (x.px !== point_x_i || x.py !== point_y_i || x.num !== point_number_i ||
              x.last !== last_point_i) begin
            if (x.px !== point_x_i) $error("point_x exp %0d got %0d", x.px, point_x_i);
            if (x.py !== point_y_i) $error("point_y exp %0d got %0d", x.py, point_y_i);
            if (x.num !== point_number_i)
              $error("point_number exp %0d got %0d", x.num, point_number_i);
            if (x.last !== last_point_i)
              $error("last_point exp %0d got %0d", x.last, last_point_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/tb_ellipse_arc_point_generator.sv
// Testbench top for the arc point generator: stimulus, handshake noise and verdict.
module tb_ellipse_arc_point_generator;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] center_x_i = '0, center_y_i = '0, radius_x_i = '0, radius_y_i = '0;
  logic signed [15:0] begin_angle_i = '0, end_angle_i = '0;
  logic sweep_increasing_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] point_x_o, point_y_o;
  logic [5:0] point_number_o;
  logic last_point_o;
  int fail_count, pending_points;
  bit quiet_phase = 1'b0;

  always #2 clk_i = ~clk_i;

  ellipse_arc_point_generator i_dut (.*);

  arc_point_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .center_x_i, .center_y_i,
    .radius_x_i, .radius_y_i, .begin_angle_i, .end_angle_i, .sweep_increasing_i,
    .out_valid_i(out_valid_o), .out_stall_i, .point_x_i(point_x_o), .point_y_i(point_y_o),
    .point_number_i(point_number_o), .last_point_i(last_point_o),
    .fail_count_o(fail_count), .pending_points_o(pending_points)
  );

  // Stall the output at random, except during the quiet phase.
  always @(posedge clk_i) begin
    out_stall_i <= !quiet_phase && ($urandom_range(99) < 11);
  end

  // Present one arc word and hold it until taken; valid stays up for the next word.
  task automatic send_arc(input logic [15:0] cx, input logic [15:0] cy,
                          input logic [15:0] rx, input logic [15:0] ry,
                          input logic [15:0] ba, input logic [15:0] ea, input logic dir);
    while (!quiet_phase && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_x_i <= rx;
    radius_y_i <= ry;
    begin_angle_i <= ba;
    end_angle_i <= ea;
    sweep_increasing_i <= dir;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ba;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero span, full turn less one, extremes, both directions.
    send_arc(0, 0, 16'h4000, 16'h4000, 0, 0, 1);
    send_arc(0, 0, 16'h4000, 16'h4000, 0, 0, 0);
    send_arc(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 0, 16'h4000, 1);
    send_arc(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h4000, 0, 0);
    send_arc(0, 0, 16'h8000, 16'h7fff, 0, 16'hffff, 1);
    send_arc(0, 0, 16'h7fff, 16'h8000, 0, 16'hffff, 0);
    send_arc(16'h1234, 16'hedcb, 16'hc000, 16'h2000, 16'h8000, 16'h7fff, 1);
    send_arc(0, 0, 16'h4000, 16'h4000, 16'h7fff, 16'h8000, 0);
    send_arc(16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h0001, 1);
    send_arc(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 1);
    send_arc(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0001, 0);
    send_arc(0, 0, 16'h4000, 16'h4000, 16'hc000, 16'h4000, 1);

    // Hold off until every expected point has arrived.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_points != 0) @(posedge clk_i);

    for (int k = 0; k < 450; k++) begin
      quiet_phase = (k >= 150 && k < 200);
      ba = 16'($urandom);
      case ($urandom_range(9))
        0: send_arc(pick_coord(), pick_coord(), pick_coord(), pick_coord(), ba, ba,
                    1'($urandom_range(1)));
        1, 2: send_arc(pick_coord(), pick_coord(), pick_coord(), pick_coord(), ba,
                       ba + 16'($urandom_range(2048)), 1'($urandom_range(1)));
        default: send_arc(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), ba,
                          16'($urandom), 1'($urandom_range(1)));
      endcase
    end
    quiet_phase = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_points != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
